// ----- rtl/ncta_pkg.sv -----
package ncta_pkg;

  localparam int unsigned NODE_W  = 8;
  localparam int unsigned COST_W  = 10;
  localparam int unsigned AGE_W   = 8;
  localparam int unsigned CNT_W   = 5;
  localparam int unsigned TMO_W   = 8;
  localparam int unsigned SLOT_W  = 4;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 8;

  // Link cost that stands for an unreachable neighbor.
  localparam logic [COST_W-1:0] INF_COST = 10'd999;
  localparam logic [TMO_W-1:0]  TIMEOUT_RESET = 8'd5;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_NEIGHBOR_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS  = 1'b1;

  typedef enum logic [1:0] {
    ACT_LOAD = 2'd0,
    ACT_GET  = 2'd1,
    ACT_SET  = 2'd2,
    ACT_TICK = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    KIND_COST   = 2'd0,
    KIND_STATUS = 2'd1,
    KIND_DOWN   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    action_t             action;
    logic [SLOT_W-1:0]   entry_index;
    logic [NODE_W-1:0]   node_id;
    logic [COST_W-1:0]   cost_value;
  } in_req_t;

  typedef struct packed {
    kind_t               kind;
    logic                found;
    logic [NODE_W-1:0]   neighbor_id;
    logic [COST_W-1:0]   cost_out;
    logic                last_result;
  } out_req_t;

  // One table entry as stored in the RAM word.
  typedef struct packed {
    logic [NODE_W-1:0]   node;
    logic [COST_W-1:0]   cost;
    logic [AGE_W-1:0]    age;
  } entry_t;

endpackage

// ----- rtl/ncta_ram.sv -----
module ncta_ram #(
  parameter int unsigned WIDTH = 26,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/neighbor_cost_table_aging.sv -----
// Channel   Direction  Handshake              Payload
// in_       request    in_valid / in_ready    in_req_t  (action, slot, node id, cost)
// out_      result     out_valid / out_ready  out_req_t (kind, found, id, cost, last)
// cfg_      write      cfg_we                 cfg_index, cfg_wdata (no read-back)
//
// A load request is written straight to its slot from idle, so in_ready stays high.
// Get, set and tick walk the slots in use through one single-port-read table RAM,
// each slot in a read step, then an evaluate and write-back step; the walk ends
// with an end check and a closing step, unless get or set stop earlier at the
// first match. The next request is accepted only once the block is back in idle.
// Reset clears control state, the slot age-valid bits and the output valid flag;
// a slot whose valid bit is clear reads age zero, so no clearing pass is run.
// A full output register stalls the walk in its evaluate or closing step where a
// result is due; in_ready is high only in idle.
module neighbor_cost_table_aging
  import ncta_pkg::*;
#(
  parameter int unsigned MAX_NEIGHBORS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_req_t               in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_req_t              out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Slot field is four bits wide, so at most sixteen slots are reachable.
  localparam int unsigned DEPTH = (MAX_NEIGHBORS < 16) ? MAX_NEIGHBORS : 16;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW    = $clog2(DEPTH + 1);

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     nbr_cnt_r;
  logic [TMO_W-1:0]     timeout_r;
  action_t              act_r, act_nxt;
  logic [NODE_W-1:0]    id_r, id_nxt;
  logic [COST_W-1:0]    cost_r, cost_nxt;
  logic [CW-1:0]        idx_r, idx_nxt;
  logic                 pend_r, pend_nxt;
  logic [NODE_W-1:0]    pend_node_r, pend_node_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_req_t             out_data_r, out_data_nxt;
  logic [DEPTH-1:0]     age_vld_r;
  logic                 rd_vld_r;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  entry_t               ram_wdata;
  logic                 ram_re;
  entry_t               ram_rdata;

  logic [CNT_W-1:0]     n_use;
  logic                 at_end;
  logic                 out_free;
  logic [COST_W-1:0]    in_cost_clamped;
  logic [AGE_W-1:0]     age_eff;
  logic [AGE_W:0]       age_inc;
  logic                 expired;
  logic                 node_match;

  ncta_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(idx_r[AW-1:0]),
    .rdata(ram_rdata)
  );

  // Slots in use, clipped to the table depth.
  assign n_use    = (nbr_cnt_r > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : nbr_cnt_r;
  assign at_end   = (CNT_W'(idx_r) >= n_use);
  assign out_free = !out_valid_r || out_ready;

  assign in_cost_clamped = (in_data.cost_value > INF_COST) ? INF_COST : in_data.cost_value;

  // Never-written slots read age zero.
  assign age_eff    = rd_vld_r ? ram_rdata.age : '0;
  assign age_inc    = {1'b0, age_eff} + (AGE_W + 1)'(1);
  assign expired    = age_inc > {1'b0, timeout_r};
  assign node_match = (ram_rdata.node == id_r);

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nbr_cnt_r <= '0;
      timeout_r <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NEIGHBOR_COUNT: nbr_cnt_r <= cfg_wdata[CNT_W-1:0];
        CFG_TIMEOUT_TICKS:  timeout_r <= cfg_wdata[TMO_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer: one slot per read/evaluate pair.
  always_comb begin
    state_nxt     = state_r;
    act_nxt       = act_r;
    id_nxt        = id_r;
    cost_nxt      = cost_r;
    idx_nxt       = idx_r;
    pend_nxt      = pend_r;
    pend_node_nxt = pend_node_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    ram_we        = 1'b0;
    ram_waddr     = idx_r[AW-1:0];
    ram_wdata     = ram_rdata;
    ram_re        = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          act_nxt  = in_data.action;
          id_nxt   = in_data.node_id;
          cost_nxt = in_cost_clamped;
          idx_nxt  = '0;
          pend_nxt = 1'b0;
          if (in_data.action == ACT_LOAD) begin
            // Write the slot directly; drop slots beyond the table.
            if (32'(in_data.entry_index) < DEPTH) begin
              ram_we    = 1'b1;
              ram_waddr = AW'(in_data.entry_index);
              ram_wdata = '{node: in_data.node_id, cost: in_cost_clamped, age: '0};
            end
          end else begin
            state_nxt = ST_READ;
          end
        end
      end

      ST_READ: begin
        if (at_end) begin
          state_nxt = ST_FLUSH;
        end else begin
          ram_re    = 1'b1;
          state_nxt = ST_EVAL;
        end
      end

      ST_EVAL: begin
        case (act_r)
          ACT_GET: begin
            if (node_match) begin
              if (out_free) begin
                out_valid_nxt = 1'b1;
                out_data_nxt  = '{kind: KIND_COST, found: 1'b1, neighbor_id: id_r,
                                  cost_out: ram_rdata.cost, last_result: 1'b1};
                state_nxt     = ST_IDLE;
              end
            end else begin
              idx_nxt   = idx_r + CW'(1);
              state_nxt = ST_READ;
            end
          end
          ACT_SET: begin
            if (node_match) begin
              if (out_free) begin
                ram_we        = 1'b1;
                ram_wdata     = '{node: ram_rdata.node, cost: cost_r, age: '0};
                out_valid_nxt = 1'b1;
                out_data_nxt  = '{kind: KIND_STATUS, found: 1'b1, neighbor_id: id_r,
                                  cost_out: cost_r, last_result: 1'b1};
                state_nxt     = ST_IDLE;
              end
            end else begin
              idx_nxt   = idx_r + CW'(1);
              state_nxt = ST_READ;
            end
          end
          ACT_TICK: begin
            // Hold a found event until the next one shows it is not the last.
            if (!(expired && (ram_rdata.cost < INF_COST) && pend_r && !out_free)) begin
              ram_we = 1'b1;
              if (expired) begin
                ram_wdata = '{node: ram_rdata.node, cost: INF_COST, age: '0};
                if (ram_rdata.cost < INF_COST) begin
                  if (pend_r) begin
                    out_valid_nxt = 1'b1;
                    out_data_nxt  = '{kind: KIND_DOWN, found: 1'b1,
                                      neighbor_id: pend_node_r, cost_out: INF_COST,
                                      last_result: 1'b0};
                  end
                  pend_nxt      = 1'b1;
                  pend_node_nxt = ram_rdata.node;
                end
              end else begin
                ram_wdata = '{node: ram_rdata.node, cost: ram_rdata.cost,
                              age: age_inc[AGE_W] ? '1 : age_inc[AGE_W-1:0]};
              end
              idx_nxt   = idx_r + CW'(1);
              state_nxt = ST_READ;
            end
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end

      ST_FLUSH: begin
        case (act_r)
          ACT_TICK: begin
            if (!pend_r) begin
              state_nxt = ST_IDLE;
            end else if (out_free) begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = '{kind: KIND_DOWN, found: 1'b1, neighbor_id: pend_node_r,
                                cost_out: INF_COST, last_result: 1'b1};
              pend_nxt      = 1'b0;
              state_nxt     = ST_IDLE;
            end
          end
          ACT_GET, ACT_SET: begin
            // No match in the slots in use.
            if (out_free) begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = '{kind: (act_r == ACT_GET) ? KIND_COST : KIND_STATUS,
                                found: 1'b0, neighbor_id: id_r, cost_out: INF_COST,
                                last_result: 1'b1};
              state_nxt     = ST_IDLE;
            end
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      age_vld_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (ram_we) begin
        age_vld_r[ram_waddr] <= 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    act_r       <= act_nxt;
    id_r        <= id_nxt;
    cost_r      <= cost_nxt;
    idx_r       <= idx_nxt;
    pend_node_r <= pend_node_nxt;
    out_data_r  <= out_data_nxt;
    if (ram_re) begin
      rd_vld_r <= age_vld_r[idx_r[AW-1:0]];
    end
  end

endmodule
